/* design/imu_angle_kalman_filter_macros.svh */
// Assertion macros shared by the angle filter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef IMU_ANGLE_KALMAN_FILTER_MACROS_SVH
`define IMU_ANGLE_KALMAN_FILTER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IAKF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define IAKF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define IAKF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define IAKF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/iakf_pkg.sv */
// Shared types, constants and saturating helpers of the angle filter.
// No dependencies.
package iakf_pkg;

	localparam int DATA_W = 32;
	localparam int COV_W  = 48;
	localparam int CFG_W  = 32;
	localparam int DT_W   = 24;
	localparam int PROD_W = 2 * COV_W;
	localparam int NUM_W  = COV_W + 32;

	localparam logic [CFG_W-1:0] Q_ANGLE_RST   = 32'd16777;
	localparam logic [CFG_W-1:0] Q_BIAS_RST    = 32'd50332;
	localparam logic [CFG_W-1:0] R_MEASURE_RST = 32'd503316;

	localparam logic [1:0] REG_Q_ANGLE   = 2'd0;
	localparam logic [1:0] REG_Q_BIAS    = 2'd1;
	localparam logic [1:0] REG_R_MEASURE = 2'd2;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_SET    = 1'b1;

	typedef enum logic [1:0] {SH_0, SH_16, SH_24, SH_32} shift_t;

	typedef struct packed {
		logic   is_div;
		shift_t sh;
		logic   narrow;
	} cmd_t;

	localparam logic signed [COV_W:0] HI_WIDE   = {2'b00, {(COV_W-1){1'b1}}};
	localparam logic signed [COV_W:0] HI_NARROW =
		{{(COV_W-DATA_W+2){1'b0}}, {(DATA_W-1){1'b1}}};

	function automatic logic signed [COV_W-1:0] sx(input logic signed [DATA_W-1:0] x);
		return {{(COV_W-DATA_W){x[DATA_W-1]}}, x};
	endfunction

	// saturating add/subtract, clamped to 32 or 48 bits
	function automatic logic signed [COV_W-1:0] add_sat(
		input logic signed [COV_W-1:0] a,
		input logic signed [COV_W-1:0] b,
		input logic sub,
		input logic narrow);
		logic signed [COV_W:0] r;
		logic signed [COV_W:0] hi;
		r  = sub ? ({a[COV_W-1], a} - {b[COV_W-1], b}) : ({a[COV_W-1], a} + {b[COV_W-1], b});
		hi = narrow ? HI_NARROW : HI_WIDE;
		if (r > hi) r = hi;
		else if (r < ~hi) r = ~hi;
		return r[COV_W-1:0];
	endfunction

endpackage

/* design/iakf_muldiv.sv */
// Shared multiply / divide unit: signed operands, truncating, saturating.
// Multiply takes 16 bits of the multiplier a cycle; divide is radix 2. Uses iakf_pkg.
module iakf_muldiv (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  iakf_pkg::cmd_t                      cmd,
	input  logic signed [iakf_pkg::COV_W-1:0]   a,
	input  logic signed [iakf_pkg::COV_W-1:0]   b,
	output logic                                done,
	output logic signed [iakf_pkg::COV_W-1:0]   result
);
	localparam int W  = iakf_pkg::COV_W;
	localparam int PW = iakf_pkg::PROD_W;
	localparam int NW = iakf_pkg::NUM_W;

	typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_FIN} ust_t;

	ust_t               st_q;
	logic [6:0]         cnt_q;
	logic               neg_q;
	iakf_pkg::cmd_t     cmd_q;
	logic [W-1:0]       amag_q, bmag_q;
	logic [PW-1:0]      acc_q;
	logic [NW-1:0]      num_q;
	logic [W-1:0]       rem_q;
	logic               done_q;
	logic signed [W-1:0] res_q;

	logic [W-1:0]  amag, bmag;
	logic [PW-1:0] mul_acc;
	logic [W:0]    rem_sh, rem_sub;
	logic          ge;
	logic [PW-1:0] shifted, lim, mag;

	assign amag = a[W-1] ? W'(-a) : W'(a);
	assign bmag = b[W-1] ? W'(-b) : W'(b);

	assign mul_acc = (acc_q << 16) + PW'(64'(amag_q) * 64'(bmag_q[W-1 -: 16]));

	assign rem_sh  = {rem_q, num_q[NW-1]};
	assign rem_sub = rem_sh - {1'b0, bmag_q};
	assign ge      = rem_sh >= {1'b0, bmag_q};

	always_comb begin
		case (cmd_q.sh)
			iakf_pkg::SH_16: shifted = acc_q >> 16;
			iakf_pkg::SH_24: shifted = acc_q >> 24;
			iakf_pkg::SH_32: shifted = acc_q >> 32;
			default:         shifted = acc_q;
		endcase
		lim = cmd_q.narrow ? PW'({(iakf_pkg::DATA_W-1){1'b1}}) : PW'({(W-1){1'b1}});
		if (neg_q) mag = (shifted > lim + 1'b1) ? lim + 1'b1 : shifted;
		else       mag = (shifted > lim) ? lim : shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= U_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				U_IDLE: begin
					if (start) begin
						cmd_q  <= cmd;
						neg_q  <= a[W-1] ^ b[W-1];
						amag_q <= amag;
						bmag_q <= bmag;
						acc_q  <= '0;
						num_q  <= {amag, 32'b0};
						rem_q  <= '0;
						cnt_q  <= '0;
						if (!cmd.is_div) st_q <= U_MUL;
						else if (b == '0) st_q <= U_FIN;
						else st_q <= U_DIV;
					end
				end
				U_MUL: begin
					acc_q  <= mul_acc;
					bmag_q <= bmag_q << 16;
					cnt_q  <= cnt_q + 7'd1;
					if (cnt_q == 7'd2) st_q <= U_FIN;
				end
				U_DIV: begin
					rem_q <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
					acc_q <= {acc_q[PW-2:0], ge};
					num_q <= num_q << 1;
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(NW - 1)) st_q <= U_FIN;
				end
				U_FIN: begin
					res_q  <= neg_q ? W'(-mag[W-1:0]) : mag[W-1:0];
					done_q <= 1'b1;
					st_q   <= U_IDLE;
				end
				default: st_q <= U_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

/* design/imu_angle_kalman_filter.sv */
// Top level of the angle / gyro-bias filter: sequencer, state and registers.
// Depends on iakf_pkg, iakf_muldiv and imu_angle_kalman_filter_macros.svh.
//
//  channel | signals                                       | dir
//  in      | in_valid in_stall opcode meas_angle gyro_rate time_step | sink
//  out     | out_valid out_stall angle_est rate_est bias_est          | source
//  cfg     | cfg_we cfg_index cfg_data                      | sink
//
// A set transaction goes straight to ST_DONE, where its result is loaded into the output
// register; the filter then returns to idle and can take the next transaction. An update
// runs ten multiplies and two divides on the one shared multiply/divide unit, seven
// steps that use only the saturating adder, and the output load.
// in_stall is high from acceptance until the result is loaded into the output
// register; a waiting result holds while out_stall is high.
// Reset is asynchronous; state and covariance clear, noise registers reload.
`include "imu_angle_kalman_filter_macros.svh"
module imu_angle_kalman_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                opcode,
	input  logic signed [31:0]                  meas_angle,
	input  logic signed [31:0]                  gyro_rate,
	input  logic [iakf_pkg::DT_W-1:0]           time_step,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [31:0]                  angle_est,
	output logic signed [31:0]                  rate_est,
	output logic signed [31:0]                  bias_est,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [iakf_pkg::CFG_W-1:0]          cfg_data
);
	localparam int W  = iakf_pkg::COV_W;
	localparam int DW = iakf_pkg::DATA_W;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RATE, ST_ANG, ST_TP, ST_T1, ST_T2, ST_P00, ST_P01, ST_P10,
		ST_P11, ST_Y, ST_S, ST_K0, ST_K1, ST_UA, ST_UB, ST_C0, ST_C1, ST_C2,
		ST_C3, ST_DONE
	} state_t;

	state_t state_q;
	logic   pend_q;
	logic   out_valid_q;
	logic [iakf_pkg::CFG_W-1:0] qa_q, qb_q, rm_q;
	logic signed [DW-1:0] ang_q, bias_q, rate_q, y_q, meas_q, gyro_q;
	logic [iakf_pkg::DT_W-1:0] dt_q;
	logic signed [W-1:0] p_q [4];
	logic signed [W-1:0] t_q, tp_q, s_q, k0_q, k1_q, p00o_q, p01o_q;
	logic signed [DW-1:0] ang_out_q, rate_out_q, bias_out_q;

	logic                u_start, u_done, unit_st;
	iakf_pkg::cmd_t      u_cmd;
	logic signed [W-1:0] u_a, u_b, u_res, dt_x;
	logic signed [W-1:0] alu_a, alu_b, alu_r;
	logic                alu_sub, alu_nar;
	logic                load_out;

	assign dt_x = {{(W-iakf_pkg::DT_W){1'b0}}, dt_q};

	always_comb begin
		unit_st = 1'b1;
		u_a     = dt_x;
		u_b     = iakf_pkg::sx(rate_q);
		u_cmd   = '{is_div: 1'b0, sh: iakf_pkg::SH_32, narrow: 1'b0};
		case (state_q)
			ST_ANG: u_cmd = '{is_div: 1'b0, sh: iakf_pkg::SH_24, narrow: 1'b1};
			ST_TP: begin
				u_b   = p_q[3];
				u_cmd = '{is_div: 1'b0, sh: iakf_pkg::SH_24, narrow: 1'b0};
			end
			ST_P00: begin
				u_b   = t_q;
				u_cmd = '{is_div: 1'b0, sh: iakf_pkg::SH_24, narrow: 1'b0};
			end
			ST_P11: begin
				u_a   = {{(W-iakf_pkg::CFG_W){1'b0}}, qb_q};
				u_b   = dt_x;
				u_cmd = '{is_div: 1'b0, sh: iakf_pkg::SH_16, narrow: 1'b0};
			end
			ST_K0: begin
				u_a   = p_q[0];
				u_b   = s_q;
				u_cmd = '{is_div: 1'b1, sh: iakf_pkg::SH_0, narrow: 1'b0};
			end
			ST_K1: begin
				u_a   = p_q[2];
				u_b   = s_q;
				u_cmd = '{is_div: 1'b1, sh: iakf_pkg::SH_0, narrow: 1'b0};
			end
			ST_UA: begin
				u_a   = k0_q;
				u_b   = iakf_pkg::sx(y_q);
				u_cmd = '{is_div: 1'b0, sh: iakf_pkg::SH_32, narrow: 1'b1};
			end
			ST_UB: begin
				u_a   = k1_q;
				u_b   = iakf_pkg::sx(y_q);
				u_cmd = '{is_div: 1'b0, sh: iakf_pkg::SH_32, narrow: 1'b1};
			end
			ST_C0: begin u_a = k0_q; u_b = p00o_q; end
			ST_C1: begin u_a = k0_q; u_b = p01o_q; end
			ST_C2: begin u_a = k1_q; u_b = p00o_q; end
			ST_C3: begin u_a = k1_q; u_b = p01o_q; end
			default: unit_st = 1'b0;
		endcase
	end

	assign u_start = unit_st && !pend_q;

	// previous result must be gone before this one is loaded
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// one saturating adder shared by all the add and subtract steps
	always_comb begin
		alu_a   = p_q[0];
		alu_b   = u_res;
		alu_sub = 1'b0;
		alu_nar = 1'b0;
		case (state_q)
			ST_RATE: begin
				alu_a = iakf_pkg::sx(gyro_q); alu_b = iakf_pkg::sx(bias_q);
				alu_sub = 1'b1; alu_nar = 1'b1;
			end
			ST_ANG, ST_UA: begin alu_a = iakf_pkg::sx(ang_q); alu_nar = 1'b1; end
			ST_UB:   begin alu_a = iakf_pkg::sx(bias_q); alu_nar = 1'b1; end
			ST_TP:   begin alu_a = u_res; alu_b = p_q[1]; alu_sub = 1'b1; end
			ST_T1:   begin alu_a = t_q; alu_b = p_q[2]; alu_sub = 1'b1; end
			ST_T2:   begin alu_a = t_q; alu_b = {8'b0, qa_q, 8'b0}; end
			ST_P01:  begin alu_a = p_q[1]; alu_b = tp_q; alu_sub = 1'b1; end
			ST_P10:  begin alu_a = p_q[2]; alu_b = tp_q; alu_sub = 1'b1; end
			ST_P11:  alu_a = p_q[3];
			ST_Y: begin
				alu_a = iakf_pkg::sx(meas_q); alu_b = iakf_pkg::sx(ang_q);
				alu_sub = 1'b1; alu_nar = 1'b1;
			end
			ST_S:    alu_b = {8'b0, rm_q, 8'b0};
			ST_C0:   alu_sub = 1'b1;
			ST_C1:   begin alu_a = p_q[1]; alu_sub = 1'b1; end
			ST_C2:   begin alu_a = p_q[2]; alu_sub = 1'b1; end
			ST_C3:   begin alu_a = p_q[3]; alu_sub = 1'b1; end
			default: alu_a = p_q[0];
		endcase
		alu_r = iakf_pkg::add_sat(alu_a, alu_b, alu_sub, alu_nar);
	end

	iakf_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (u_start),
		.cmd    (u_cmd),
		.a      (u_a),
		.b      (u_b),
		.done   (u_done),
		.result (u_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			qa_q        <= iakf_pkg::Q_ANGLE_RST;
			qb_q        <= iakf_pkg::Q_BIAS_RST;
			rm_q        <= iakf_pkg::R_MEASURE_RST;
			ang_q       <= '0;
			bias_q      <= '0;
			rate_q      <= '0;
			p_q[0]      <= '0;
			p_q[1]      <= '0;
			p_q[2]      <= '0;
			p_q[3]      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					iakf_pkg::REG_Q_ANGLE:   qa_q <= cfg_data;
					iakf_pkg::REG_Q_BIAS:    qb_q <= cfg_data;
					iakf_pkg::REG_R_MEASURE: rm_q <= cfg_data;
					default: ;
				endcase
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (u_start) pend_q <= 1'b1;
			if (u_done) pend_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						meas_q <= meas_angle;
						gyro_q <= gyro_rate;
						dt_q   <= time_step;
						if (opcode == iakf_pkg::OP_SET) begin
							ang_q   <= meas_angle;
							p_q[0]  <= '0;
							p_q[1]  <= '0;
							p_q[2]  <= '0;
							p_q[3]  <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RATE;
						end
					end
				end
				ST_RATE: begin rate_q <= alu_r[DW-1:0]; state_q <= ST_ANG; end
				ST_ANG: if (u_done) begin ang_q <= alu_r[DW-1:0]; state_q <= ST_TP; end
				ST_TP: if (u_done) begin tp_q <= u_res; t_q <= alu_r; state_q <= ST_T1; end
				ST_T1: begin t_q <= alu_r; state_q <= ST_T2; end
				ST_T2: begin t_q <= alu_r; state_q <= ST_P00; end
				ST_P00: if (u_done) begin p_q[0] <= alu_r; state_q <= ST_P01; end
				ST_P01: begin p_q[1] <= alu_r; state_q <= ST_P10; end
				ST_P10: begin p_q[2] <= alu_r; state_q <= ST_P11; end
				ST_P11: if (u_done) begin p_q[3] <= alu_r; state_q <= ST_Y; end
				ST_Y: begin
					y_q     <= alu_r[DW-1:0];
					p00o_q  <= p_q[0];
					p01o_q  <= p_q[1];
					state_q <= ST_S;
				end
				ST_S: begin s_q <= alu_r; state_q <= ST_K0; end
				ST_K0: if (u_done) begin k0_q <= u_res; state_q <= ST_K1; end
				ST_K1: if (u_done) begin k1_q <= u_res; state_q <= ST_UA; end
				ST_UA: if (u_done) begin ang_q <= alu_r[DW-1:0]; state_q <= ST_UB; end
				ST_UB: if (u_done) begin bias_q <= alu_r[DW-1:0]; state_q <= ST_C0; end
				ST_C0: if (u_done) begin p_q[0] <= alu_r; state_q <= ST_C1; end
				ST_C1: if (u_done) begin p_q[1] <= alu_r; state_q <= ST_C2; end
				ST_C2: if (u_done) begin p_q[2] <= alu_r; state_q <= ST_C3; end
				ST_C3: if (u_done) begin p_q[3] <= alu_r; state_q <= ST_DONE; end
				ST_DONE: begin
					if (load_out) begin
						ang_out_q  <= ang_q;
						rate_out_q <= rate_q;
						bias_out_q <= bias_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign angle_est = ang_out_q;
	assign rate_est  = rate_out_q;
	assign bias_est  = bias_out_q;

	`IAKF_ASSERT_IMP(a_done_pending, clk, arst_n, u_done, pend_q, "unit result with no request")
	`IAKF_ASSERT_NXT(a_set_short, clk, arst_n, in_valid && !in_stall && opcode == iakf_pkg::OP_SET, state_q == ST_DONE, "set transaction did not go straight to result")
	`IAKF_ASSERT_NXT(a_hold_result, clk, arst_n, state_q == ST_DONE && out_valid_q && out_stall, state_q == ST_DONE && out_valid_q, "result overwritten while stalled")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench of imu_angle_kalman_filter: a directed table and then random
// transactions, each checked against the bench's fixed-point filter model or a typed expectation.
// Depends on iakf_pkg and the imu_angle_kalman_filter RTL.
`timescale 1ns / 100ps
module tb_top;

	typedef struct {
		logic signed [31:0] angle;
		logic signed [31:0] rate;
		logic signed [31:0] bias;
	} est_t;

	typedef struct {
		logic               op;
		logic signed [31:0] meas;
		logic signed [31:0] gyro;
		logic [23:0]        dt;
		bit                 typed;
		est_t               want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = iakf_pkg::OP_UPDATE;
	logic signed [31:0] meas_angle = '0;
	logic signed [31:0] gyro_rate = '0;
	logic [iakf_pkg::DT_W-1:0] time_step = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] angle_est, rate_est, bias_est;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = iakf_pkg::REG_Q_ANGLE;
	logic [iakf_pkg::CFG_W-1:0] cfg_data = '0;

	imu_angle_kalman_filter dut (.*);

	always #5 clk = ~clk;

	// filter model state
	longint m_q_angle, m_q_bias, m_r_meas;
	longint m_angle, m_bias, m_rate;
	longint m_cov[4];

	est_t   est_q[$];
	int     mismatches = 0;
	int     idle_cycles = 0;
	bit     timed_out = 0;
	bit     idle_en = 1;
	int     hold_req = 0;
	bit     in_acc, out_acc;

	function automatic longint sat_w(logic signed [65:0] v, int w);
		logic signed [65:0] hi;
		hi = (66'sd1 <<< (w - 1)) - 66'sd1;
		if (v > hi) return longint'(hi[63:0]);
		if (v < -hi - 66'sd1) return -longint'(hi[63:0]) - 64'sd1;
		return longint'(v[63:0]);
	endfunction

	function automatic longint sadd(longint a, longint b, int w);
		logic signed [65:0] r;
		r = a;
		r = r + b;
		return sat_w(r, w);
	endfunction

	function automatic longint ssub(longint a, longint b, int w);
		logic signed [65:0] r;
		r = a;
		r = r - b;
		return sat_w(r, w);
	endfunction

	function automatic logic [63:0] mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint pack_sat(bit neg, logic [127:0] p, int w);
		logic [127:0] lim;
		lim = (128'd1 << (w - 1)) - 128'd1;
		if (neg) begin
			if (p > lim + 128'd1) p = lim + 128'd1;
			return -longint'(p[63:0]);
		end
		if (p > lim) p = lim;
		return longint'(p[63:0]);
	endfunction

	function automatic longint mul_q(longint a, longint b, int sh, int w);
		logic [127:0] p;
		p = {64'd0, mag(a)} * {64'd0, mag(b)};
		p = p >> sh;
		return pack_sat((a < 0) != (b < 0), p, w);
	endfunction

	function automatic longint div_q(longint n, longint d, int sh, int w);
		logic [127:0] p;
		if (d == 0) return 0;
		p = ({64'd0, mag(n)} << sh) / {64'd0, mag(d)};
		return pack_sat((n < 0) != (d < 0), p, w);
	endfunction

	task automatic filter_step(input logic op, input logic signed [31:0] meas,
			input logic signed [31:0] gyro, input logic [23:0] dt_in, output est_t e);
		longint p00, p01, p10, p11, t, y, s, k0, k1, dt;
		dt = dt_in;
		if (op == iakf_pkg::OP_SET) begin
			m_angle = meas;
			foreach (m_cov[i]) m_cov[i] = 0;
		end else begin
			m_rate  = ssub(gyro, m_bias, iakf_pkg::DATA_W);
			m_angle = sadd(m_angle, mul_q(dt, m_rate, 24, iakf_pkg::DATA_W),
				iakf_pkg::DATA_W);
			p00 = m_cov[0]; p01 = m_cov[1]; p10 = m_cov[2]; p11 = m_cov[3];
			t = mul_q(dt, p11, 24, iakf_pkg::COV_W);
			t = ssub(t, p01, iakf_pkg::COV_W);
			t = ssub(t, p10, iakf_pkg::COV_W);
			t = sadd(t, m_q_angle << 8, iakf_pkg::COV_W);
			p00 = sadd(p00, mul_q(dt, t, 24, iakf_pkg::COV_W), iakf_pkg::COV_W);
			t = mul_q(dt, p11, 24, iakf_pkg::COV_W);
			p01 = ssub(p01, t, iakf_pkg::COV_W);
			p10 = ssub(p10, t, iakf_pkg::COV_W);
			p11 = sadd(p11, mul_q(m_q_bias, dt, 16, iakf_pkg::COV_W), iakf_pkg::COV_W);
			y  = ssub(meas, m_angle, iakf_pkg::DATA_W);
			s  = sadd(p00, m_r_meas << 8, iakf_pkg::COV_W);
			k0 = div_q(p00, s, 32, iakf_pkg::COV_W);
			k1 = div_q(p10, s, 32, iakf_pkg::COV_W);
			m_angle = sadd(m_angle, mul_q(k0, y, 32, iakf_pkg::DATA_W), iakf_pkg::DATA_W);
			m_bias  = sadd(m_bias, mul_q(k1, y, 32, iakf_pkg::DATA_W), iakf_pkg::DATA_W);
			// correction uses pre-correction P00 / P01 throughout
			m_cov[0] = ssub(p00, mul_q(k0, p00, 32, iakf_pkg::COV_W), iakf_pkg::COV_W);
			m_cov[1] = ssub(p01, mul_q(k0, p01, 32, iakf_pkg::COV_W), iakf_pkg::COV_W);
			m_cov[2] = ssub(p10, mul_q(k1, p00, 32, iakf_pkg::COV_W), iakf_pkg::COV_W);
			m_cov[3] = ssub(p11, mul_q(k1, p01, 32, iakf_pkg::COV_W), iakf_pkg::COV_W);
		end
		e.angle = m_angle[31:0];
		e.rate  = m_rate[31:0];
		e.bias  = m_bias[31:0];
	endtask

	// one input transaction; valid stays high into the next call when there is no gap
	task automatic send_item(input row_t r);
		bit acc;
		est_t e;
		if (idle_en && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 60);
		end
		in_valid   <= 1'b1;
		opcode     <= r.op;
		meas_angle <= r.meas;
		gyro_rate  <= r.gyro;
		time_step  <= r.dt;
		forever begin
			@(negedge clk);
			acc = !in_stall;
			@(posedge clk);
			if (acc) break;
		end
		filter_step(r.op, r.meas, r.gyro, r.dt, e);
		est_q.push_back(r.typed ? r.want : e);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == iakf_pkg::REG_Q_ANGLE) m_q_angle = val;
		else if (idx == iakf_pkg::REG_Q_BIAS) m_q_bias = val;
		else m_r_meas = val;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (est_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic row_t rnd_row();
		row_t r;
		int k;
		r.typed = 0;
		r.op = ($urandom_range(99) < 10) ? iakf_pkg::OP_SET : iakf_pkg::OP_UPDATE;
		k = $urandom_range(9);
		r.meas = (k < 7) ? 32'(m_angle + $signed(32'($urandom_range(262143))) - 131072)
			: $urandom;
		k = $urandom_range(9);
		r.gyro = (k < 7) ? $signed(32'($urandom_range(2097151))) - 1048576 : $urandom;
		k = $urandom_range(9);
		r.dt = (k < 8) ? 24'($urandom_range(400000)) : 24'($urandom);
		return r;
	endfunction

	// receiver back-pressure, with a long counted hold on request
	always @(posedge clk) begin
		if (hold_req > 0) begin
			out_stall <= 1'b1;
			hold_req  <= hold_req - 1;
		end else if (idle_en)
			out_stall <= ($urandom_range(99) < 18);
		else
			out_stall <= 1'b0;
	end

	always @(negedge clk) begin
		in_acc  = in_valid && !in_stall;
		out_acc = out_valid && !out_stall;
		if (out_acc && arst_n) begin
			if (est_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %0d %0d %0d",
					angle_est, rate_est, bias_est);
			end else begin
				est_t w;
				w = est_q.pop_front();
				if (w.angle !== angle_est || w.rate !== rate_est || w.bias !== bias_est) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
							w.angle, w.rate, w.bias, angle_est, rate_est, bias_est);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (in_acc || out_acc) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles == 6000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		row_t tab[$];
		row_t r;
		m_q_angle = iakf_pkg::Q_ANGLE_RST;
		m_q_bias  = iakf_pkg::Q_BIAS_RST;
		m_r_meas  = iakf_pkg::R_MEASURE_RST;
		m_angle = 0; m_bias = 0; m_rate = 0;
		foreach (m_cov[i]) m_cov[i] = 0;

		// op, meas, gyro, dt, typed, expected
		tab.push_back('{iakf_pkg::OP_SET, 32'sh7fffffff, 0, 0, 1, '{32'sh7fffffff, 0, 0}});
		tab.push_back('{iakf_pkg::OP_SET, 32'sh80000000, 0, 0, 1, '{32'sh80000000, 0, 0}});
		// zero time step: angle held, gains zero with P still clear
		tab.push_back('{iakf_pkg::OP_UPDATE, 123, 32'sh7fffffff, 0, 1,
			'{32'sh80000000, 32'sh7fffffff, 0}});
		tab.push_back('{iakf_pkg::OP_UPDATE, 32'sh7fffffff, 32'sh80000000, 0, 1,
			'{32'sh80000000, 32'sh80000000, 0}});
		// set keeps rate and bias
		tab.push_back('{iakf_pkg::OP_SET, 0, 5, 77, 1, '{0, 32'sh80000000, 0}});
		tab.push_back('{iakf_pkg::OP_UPDATE, 32'sh7fffffff, 32'sh7fffffff, 24'hffffff, 0,
			'{0, 0, 0}});
		tab.push_back('{iakf_pkg::OP_UPDATE, 32'sh80000000, 32'sh80000000, 24'hffffff, 0,
			'{0, 0, 0}});
		tab.push_back('{iakf_pkg::OP_UPDATE, 0, 0, 1, 0, '{0, 0, 0}});
		for (int i = 0; i < 6; i++)
			tab.push_back('{iakf_pkg::OP_UPDATE, 32'sh10000, 32'sh10000, 24'h28f5c, 0,
				'{0, 0, 0}});
		tab.push_back('{iakf_pkg::OP_UPDATE, -32'sh30000, 32'sh8000, 24'h0a3d7, 0,
			'{0, 0, 0}});
		tab.push_back('{iakf_pkg::OP_SET, 32'sh10000, 0, 0, 0, '{0, 0, 0}});
		tab.push_back('{iakf_pkg::OP_UPDATE, 32'sh12000, -32'sh20000, 24'h800000, 0,
			'{0, 0, 0}});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (tab[i]) send_item(tab[i]);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					write_reg(iakf_pkg::REG_Q_ANGLE, 32'hffffffff);
					write_reg(iakf_pkg::REG_Q_BIAS, 32'hffffffff);
					write_reg(iakf_pkg::REG_R_MEASURE, 32'd1);
				end
				1: begin
					write_reg(iakf_pkg::REG_Q_ANGLE, 32'd0);
					write_reg(iakf_pkg::REG_Q_BIAS, 32'd0);
					write_reg(iakf_pkg::REG_R_MEASURE, 32'hffffffff);
				end
				2: begin
					write_reg(iakf_pkg::REG_Q_ANGLE, iakf_pkg::Q_ANGLE_RST);
					write_reg(iakf_pkg::REG_Q_BIAS, iakf_pkg::Q_BIAS_RST);
					write_reg(iakf_pkg::REG_R_MEASURE, iakf_pkg::R_MEASURE_RST);
				end
				default: begin
					write_reg(iakf_pkg::REG_Q_ANGLE, $urandom_range(2000000));
					write_reg(iakf_pkg::REG_Q_BIAS, $urandom_range(2000000));
					write_reg(iakf_pkg::REG_R_MEASURE, $urandom_range(4000000) + 1);
				end
			endcase
			for (int n = 0; n < 220; n++) begin
				if (ph == 2 && n == 40) hold_req = 700;
				idle_en = !(ph == 3 && n >= 50 && n < 170);
				// sender waits for every result now and then
				if (n % 73 == 72) begin
					in_valid <= 1'b0;
					while (est_q.size() != 0) @(posedge clk);
				end
				r = rnd_row();
				send_item(r);
			end
			idle_en = 1;
			drain();
		end

		if (mismatches == 0 && est_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/iakf_pkg.sv
design/iakf_muldiv.sv
design/imu_angle_kalman_filter.sv
tb/tb_top.sv
